// ===== rtl/whpt_pkg.sv =====
// Shared constants, codes and types of the weighted histogram peak tracker.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package whpt_pkg;

  localparam int MAX_BINS    = 256;
  localparam int BIN_WIDTH   = 40;
  localparam int STORE_DEPTH = MAX_BINS + 2;
  localparam int IDX_W       = 9;
  localparam int N_W         = 9;
  localparam int SMP_W       = 16;
  localparam int VAL_W       = 40;
  localparam int TOTAL_W     = 48;
  localparam int COUNT_W     = 32;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int PROD_W      = 34;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_FILL  = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RANGE_LOW   = 2'd0;
  localparam cfg_idx_t CFG_BIN_SCALE   = 2'd1;
  localparam cfg_idx_t CFG_BINS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                    fill_en;
    logic                    clear_en;
    logic [IDX_W-1:0]        bin;
    logic [N_W-1:0]          n;
    logic signed [SMP_W-1:0] weight;
  } upd_ctl_t;

  typedef struct packed {
    logic signed [BIN_WIDTH-1:0] peak_value;
    logic [IDX_W-1:0]            peak_bin;
    logic signed [BIN_WIDTH-1:0] min_value;
    logic signed [TOTAL_W-1:0]   total_weight;
    logic [COUNT_W-1:0]          entry_count;
  } stats_t;

endpackage

// ===== rtl/whpt_if.sv =====
// Request and result channel interfaces (valid/ready) of the histogram block.
// Depends on whpt_pkg for field widths.
`timescale 1ns / 1ps

interface whpt_req_if;
  logic                             valid;
  logic                             ready;
  logic [whpt_pkg::OP_W-1:0]        operation;
  logic signed [whpt_pkg::SMP_W-1:0] sample;
  logic signed [whpt_pkg::SMP_W-1:0] weight;
  logic [whpt_pkg::IDX_W-1:0]       bin_index;

  modport source (output valid, operation, sample, weight, bin_index, input ready);
  modport sink   (input valid, operation, sample, weight, bin_index, output ready);
endinterface

interface whpt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [whpt_pkg::VAL_W-1:0]   bin_value;
  logic [whpt_pkg::IDX_W-1:0]          filled_bin;
  logic signed [whpt_pkg::VAL_W-1:0]   peak_value;
  logic [whpt_pkg::IDX_W-1:0]          peak_bin;
  logic signed [whpt_pkg::VAL_W-1:0]   min_value;
  logic signed [whpt_pkg::TOTAL_W-1:0] total_weight;
  logic [whpt_pkg::COUNT_W-1:0]        entry_count;
  logic                                index_error;

  modport source (output valid, bin_value, filled_bin, peak_value, peak_bin, min_value,
                  total_weight, entry_count, index_error, input ready);
  modport sink   (input valid, bin_value, filled_bin, peak_value, peak_bin, min_value,
                  total_weight, entry_count, index_error, output ready);
endinterface

// ===== rtl/whpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module whpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/whpt_bin_map.sv =====
// Sample-to-bin mapping: registered (sample - range_low) * bin_scale product,
// then floor, offset and underflow/overflow clamp. Depends on whpt_pkg.
`timescale 1ns / 1ps

module whpt_bin_map (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [whpt_pkg::SMP_W-1:0] sample,
  input  logic signed [whpt_pkg::SMP_W-1:0] range_low,
  input  logic [whpt_pkg::CFG_W-1:0]        bin_scale,
  input  logic [whpt_pkg::N_W-1:0]          n,
  output logic [whpt_pkg::IDX_W-1:0]        bin
);

  logic signed [whpt_pkg::SMP_W:0]    diff;
  logic signed [whpt_pkg::PROD_W-1:0] prod_r;
  logic                               over;

  assign diff = $signed({sample[whpt_pkg::SMP_W-1], sample})
              - $signed({range_low[whpt_pkg::SMP_W-1], range_low});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= diff * $signed({1'b0, bin_scale});
    end
  end

  // product is Q.16; arithmetic floor is the upper bits, negative means underflow
  assign over = prod_r[32:16] >= {8'd0, n};

  always_comb begin
    priority if (prod_r[whpt_pkg::PROD_W-1]) begin
      bin = '0;
    end else if (over) begin
      bin = n + 9'd1;
    end else begin
      bin = prod_r[24:16] + 9'd1;
    end
  end

endmodule

// ===== rtl/whpt_stats.sv =====
// Saturating bin add and the running statistics (peak, minimum, total, count).
// Depends on whpt_pkg for the control and statistics structs.
`timescale 1ns / 1ps

module whpt_stats (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  whpt_pkg::upd_ctl_t                    ctl,
  input  logic signed [whpt_pkg::BIN_WIDTH-1:0] bin_old,
  output logic signed [whpt_pkg::BIN_WIDTH-1:0] bin_new,
  output whpt_pkg::stats_t                      stats_nxt
);

  localparam int BW = whpt_pkg::BIN_WIDTH;
  localparam int TW = whpt_pkg::TOTAL_W;

  whpt_pkg::stats_t stats_r;
  logic signed [BW:0] bin_sum;
  logic signed [TW:0] tot_sum;
  logic signed [TW-1:0] tot_new;
  logic               in_range;

  assign bin_sum = $signed({bin_old[BW-1], bin_old})
                 + $signed({{(BW-15){ctl.weight[15]}}, ctl.weight});

  always_comb begin
    if (bin_sum[BW] != bin_sum[BW-1]) begin
      bin_new = bin_sum[BW] ? {1'b1, {(BW-1){1'b0}}} : {1'b0, {(BW-1){1'b1}}};
    end else begin
      bin_new = bin_sum[BW-1:0];
    end
  end

  assign tot_sum = $signed({stats_r.total_weight[TW-1], stats_r.total_weight})
                 + $signed({{(TW-15){ctl.weight[15]}}, ctl.weight});

  always_comb begin
    if (tot_sum[TW] != tot_sum[TW-1]) begin
      tot_new = tot_sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      tot_new = tot_sum[TW-1:0];
    end
  end

  assign in_range = (ctl.bin != '0) && (ctl.bin <= ctl.n);

  always_comb begin
    stats_nxt = stats_r;
    priority if (ctl.clear_en) begin
      stats_nxt = '0;
    end else if (ctl.fill_en) begin
      if (in_range && (bin_new > stats_r.peak_value)) begin
        stats_nxt.peak_value = bin_new;
        stats_nxt.peak_bin   = ctl.bin;
      end
      if (in_range && (bin_new < stats_r.min_value)) begin
        stats_nxt.min_value = bin_new;
      end
      stats_nxt.total_weight = tot_new;
      if (!(&stats_r.entry_count)) begin
        stats_nxt.entry_count = stats_r.entry_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r <= '0;
    end else begin
      stats_r <= stats_nxt;
    end
  end

endmodule

// ===== rtl/weighted_histogram_peak_tracker_top.sv =====
// Top level of the weighted histogram peak tracker: control, bin store, output register.
// Depends on whpt_pkg, whpt_if, whpt_ram, whpt_bin_map and whpt_stats.
`timescale 1ns / 1ps

// Weighted 1D histogram with underflow (bin 0) and overflow (bin n+1) bins kept in a
// 258 x 40-bit RAM with registered read. Fill and read requests each pass a lookup
// state that issues the RAM read, then an update state that writes a filled bin back,
// loads the result register and accepts the next request once that register is free,
// so the single read-modify-write of the bin store sets the rate. A clear request
// sweeps the store one entry per cycle. After reset the same sweep covers all 258
// entries with in_req.ready low. Configuration writes take effect at the next edge
// and must only be issued while no request is in flight.
module weighted_histogram_peak_tracker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  whpt_req_if.sink                          in_req,
  whpt_rsp_if.source                        out_rsp,
  input  logic                              cfg_we,
  input  logic [whpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [whpt_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(whpt_pkg::STORE_DEPTH);

  // configuration
  logic signed [whpt_pkg::SMP_W-1:0] range_low_r;
  logic [whpt_pkg::CFG_W-1:0]        bin_scale_r;
  logic [whpt_pkg::N_W-1:0]          bins_in_use_r;
  logic [whpt_pkg::N_W-1:0]          n;
  logic [whpt_pkg::N_W:0]            n_plus1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      bin_scale_r   <= 16'd256;
      bins_in_use_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        whpt_pkg::CFG_RANGE_LOW:   range_low_r   <= cfg_data;
        whpt_pkg::CFG_BIN_SCALE:   bin_scale_r   <= cfg_data;
        whpt_pkg::CFG_BINS_IN_USE: bins_in_use_r <= cfg_data[whpt_pkg::N_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (bins_in_use_r == '0) begin
      n = 9'd1;
    end else if (bins_in_use_r > 9'(whpt_pkg::MAX_BINS)) begin
      n = 9'(whpt_pkg::MAX_BINS);
    end else begin
      n = bins_in_use_r;
    end
  end
  assign n_plus1 = {1'b0, n} + 10'd1;

  // control state
  whpt_pkg::state_t             state_r, state_nxt;
  whpt_pkg::op_t                op_r;
  logic signed [whpt_pkg::SMP_W-1:0] weight_r;
  logic [whpt_pkg::IDX_W-1:0]   index_r;
  logic [whpt_pkg::IDX_W-1:0]   bin_r, bin_nxt;
  logic                         err_r, err_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  logic                         out_valid_r;
  logic                         out_free;
  logic                         accept;
  logic                         commit;
  logic                         lookup_clear;

  // bin store access
  logic                                ram_we, ram_re;
  logic [AW-1:0]                       ram_waddr, ram_raddr;
  logic [whpt_pkg::BIN_WIDTH-1:0]      ram_wdata, ram_rdata;
  logic [whpt_pkg::IDX_W-1:0]          map_bin;
  logic signed [whpt_pkg::BIN_WIDTH-1:0] bin_new;
  whpt_pkg::upd_ctl_t                  upd;
  whpt_pkg::stats_t                    stats_nxt;

  assign out_free      = !out_valid_r || out_rsp.ready;
  assign in_req.ready  = (state_r == whpt_pkg::ST_IDLE)
                      || ((state_r == whpt_pkg::ST_UPDATE) && out_free);
  assign accept        = in_req.valid && in_req.ready;
  assign commit        = (state_r == whpt_pkg::ST_UPDATE) && out_free;
  assign lookup_clear  = (state_r == whpt_pkg::ST_LOOKUP) && (op_r == whpt_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= whpt_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      op_r       <= whpt_pkg::OP_NONE;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (accept) begin
        op_r <= in_req.operation;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r <= in_req.weight;
      index_r  <= in_req.bin_index;
    end
    if (state_r == whpt_pkg::ST_LOOKUP) begin
      bin_r <= bin_nxt;
      err_r <= err_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = '0;
    bin_nxt      = '0;
    err_nxt      = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    unique case (state_r)
      whpt_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(whpt_pkg::STORE_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          // the sweep after reset produces no result
          state_nxt = (op_r == whpt_pkg::OP_CLEAR) ? whpt_pkg::ST_UPDATE : whpt_pkg::ST_IDLE;
        end
      end
      whpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = whpt_pkg::ST_LOOKUP;
        end
      end
      whpt_pkg::ST_LOOKUP: begin
        state_nxt = whpt_pkg::ST_UPDATE;
        unique case (op_r)
          whpt_pkg::OP_FILL: begin
            bin_nxt   = map_bin;
            ram_re    = 1'b1;
            ram_raddr = map_bin;
          end
          whpt_pkg::OP_READ: begin
            bin_nxt = index_r;
            err_nxt = {1'b0, index_r} > n_plus1;
            ram_re  = !err_nxt;
            ram_raddr = err_nxt ? '0 : index_r;
          end
          whpt_pkg::OP_CLEAR: begin
            state_nxt = whpt_pkg::ST_CLEAR;
          end
          default: ;
        endcase
      end
      whpt_pkg::ST_UPDATE: begin
        if (commit) begin
          state_nxt = accept ? whpt_pkg::ST_LOOKUP : whpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = whpt_pkg::ST_IDLE;
    endcase
  end

  // write port: clearing sweep or fill write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (state_r == whpt_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
    end else if (commit && (op_r == whpt_pkg::OP_FILL)) begin
      ram_we    = 1'b1;
      ram_waddr = bin_r;
      ram_wdata = bin_new;
    end
  end

  assign upd.fill_en  = commit && (op_r == whpt_pkg::OP_FILL);
  assign upd.clear_en = lookup_clear;
  assign upd.bin      = bin_r;
  assign upd.n        = n;
  assign upd.weight   = weight_r;

  whpt_ram #(
    .WIDTH (whpt_pkg::BIN_WIDTH),
    .DEPTH (whpt_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  whpt_bin_map u_bin_map (
    .clk       (clk),
    .load      (accept),
    .sample    (in_req.sample),
    .range_low (range_low_r),
    .bin_scale (bin_scale_r),
    .n         (n),
    .bin       (map_bin)
  );

  whpt_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (upd),
    .bin_old   (ram_rdata),
    .bin_new   (bin_new),
    .stats_nxt (stats_nxt)
  );

  // result register, holds a statistics snapshot taken at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rsp.peak_value   <= stats_nxt.peak_value;
      out_rsp.peak_bin     <= stats_nxt.peak_bin;
      out_rsp.min_value    <= stats_nxt.min_value;
      out_rsp.total_weight <= stats_nxt.total_weight;
      out_rsp.entry_count  <= stats_nxt.entry_count;
      unique case (op_r)
        whpt_pkg::OP_FILL: begin
          out_rsp.bin_value   <= bin_new;
          out_rsp.filled_bin  <= bin_r;
          out_rsp.index_error <= 1'b0;
        end
        whpt_pkg::OP_READ: begin
          out_rsp.bin_value   <= err_r ? '0 : ram_rdata;
          out_rsp.filled_bin  <= bin_r;
          out_rsp.index_error <= err_r;
        end
        default: begin
          out_rsp.bin_value   <= '0;
          out_rsp.filled_bin  <= '0;
          out_rsp.index_error <= 1'b0;
        end
      endcase
    end
  end

  assign out_rsp.valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == whpt_pkg::ST_CLEAR) |-> !in_req.ready)
    else $error("request accepted during store sweep");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == whpt_pkg::ST_CLEAR) || (state_r == whpt_pkg::ST_UPDATE)))
    else $error("bin store written outside sweep or update");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> ({1'b0, ram_raddr} < 10'(whpt_pkg::STORE_DEPTH)))
    else $error("bin store read beyond depth");

  a_peak_min_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_rsp.peak_value >= 0) && (out_rsp.min_value <= 0)))
    else $error("peak below zero or minimum above zero");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_rsp.index_error |-> (out_rsp.bin_value == '0))
    else $error("index error with nonzero bin value");
`endif

endmodule
